@@ src/pimv_pkg.sv @@
// Shared constants, command codes and control/status types for the perturbed matvec row core.
`timescale 1ns / 1ps
package pimv_pkg;

	localparam int ROWS_DEF = 256;
	localparam int COLS_DEF = 256;

	localparam logic [2:0] CMD_WR_W    = 3'd0;
	localparam logic [2:0] CMD_WR_A    = 3'd1;
	localparam logic [2:0] CMD_WR_B    = 3'd2;
	localparam logic [2:0] CMD_WR_X    = 3'd3;
	localparam logic [2:0] CMD_COMPUTE = 3'd4;

	localparam logic [8:0] COLS_RESET = 9'd256;

	localparam int PERT_SHIFT = 4;
	localparam int TOT_SHIFT  = 8;
	localparam int CLAMP_HI   = 127;
	localparam int CLAMP_LO   = -127;

	typedef struct packed {
		logic accept;
		logic rd_en;
		logic mac_en;
		logic pert_en;
		logic sum_en;
		logic out_load;
	} dp_cmd_t;

	typedef struct packed {
		logic comp_ok;
		logic n_zero;
		logic last_col;
	} dp_stat_t;

endpackage

@@ src/perturbed_int8_matvec_row_core.sv @@
// Top level of the perturbed int8 matrix-vector row core: APB register and core wiring.
//
// Usage:
//   Input requests (in_valid/in_ready) carry cmd, row, col, value and negate.
//   Commands 0..3 write one element of W, A, B or x and leave the core idle;
//   other unused codes and out-of-range indexes are dropped without a result.
//   Command 4 computes one row: the x.B and x.W[row] sums are swept one
//   column per cycle through the store read ports, followed by the
//   perturbation multiply, the shifted sum and the clamp.
//   A compute request holds in_ready low until its result is loaded into
//   the output register; the sweep covers n columns (n = cols_in_use,
//   saturated to COLS). Writes sustain one per cycle while no compute
//   is in progress. A column count of zero skips the sweep and the drain step.
//   The result (result_value, result_row) sits in an output register, so
//   write requests keep flowing while out_ready is low; a compute stalls in
//   its final step only while an earlier result is still waiting.
//   Reset clears control state and sets cols_in_use to 256; store contents
//   are undefined until written. cols_in_use is at APB byte address 0.
`timescale 1ns / 1ps
module perturbed_int8_matvec_row_core #(
	parameter int ROWS = pimv_pkg::ROWS_DEF,
	parameter int COLS = pimv_pkg::COLS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [2:0]        paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [2:0]        cmd,
	input  logic [7:0]        row,
	input  logic [7:0]        col,
	input  logic signed [7:0] value,
	input  logic              negate,
	output logic              out_valid,
	input  logic              out_ready,
	output logic signed [7:0] result_value,
	output logic [7:0]        result_row
);
	import pimv_pkg::*;

	logic [8:0] cols_in_use_q;
	dp_cmd_t    dp_cmd;
	dp_stat_t   dp_stat;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cols_in_use_q <= COLS_RESET;
		end else if (psel && penable && pwrite && pready && !paddr[2]) begin
			cols_in_use_q <= pwdata[8:0];
		end
	end

	assign prdata = paddr[2] ? 32'b0 : {23'b0, cols_in_use_q};

	pimv_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.dp_stat   (dp_stat),
		.dp_cmd    (dp_cmd)
	);

	pimv_datapath #(.ROWS(ROWS), .COLS(COLS)) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.dp_cmd       (dp_cmd),
		.dp_stat      (dp_stat),
		.cols_in_use  (cols_in_use_q),
		.cmd          (cmd),
		.row          (row),
		.col          (col),
		.value        (value),
		.negate       (negate),
		.result_value (result_value),
		.result_row   (result_row)
	);

endmodule

@@ src/pimv_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module pimv_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256,
	parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

@@ src/pimv_datapath.sv @@
// Datapath: element stores, column counter, dot-product accumulators, perturbation and clamp.
`timescale 1ns / 1ps
module pimv_datapath #(
	parameter int ROWS = pimv_pkg::ROWS_DEF,
	parameter int COLS = pimv_pkg::COLS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  pimv_pkg::dp_cmd_t dp_cmd,
	output pimv_pkg::dp_stat_t dp_stat,
	input  logic [8:0]        cols_in_use,
	input  logic [2:0]        cmd,
	input  logic [7:0]        row,
	input  logic [7:0]        col,
	input  logic signed [7:0] value,
	input  logic              negate,
	output logic signed [7:0] result_value,
	output logic [7:0]        result_row
);
	import pimv_pkg::*;

	localparam int RIW   = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam int CIW   = (COLS > 1) ? $clog2(COLS) : 1;
	localparam int CW    = $clog2(COLS + 1);
	localparam int WAW   = (ROWS * COLS > 1) ? $clog2(ROWS * COLS) : 1;
	localparam int ACC_W = 17 + CIW;
	localparam int PW    = ACC_W + 8;
	localparam int SW    = PW + 2;

	logic [15:0]    row16, col16;
	logic           row_ok, col_ok;
	logic [RIW-1:0] row_ix;
	logic [CIW-1:0] col_ix;
	logic [WAW-1:0] row_base, w_waddr, w_raddr;
	logic [CW-1:0]  cols_eff;
	logic           is_comp;

	logic [CW-1:0]  j_q, n_q;
	logic [WAW-1:0] base_addr_q;
	logic           neg_q;
	logic [7:0]     row_q;

	logic signed [7:0]  x_rd, b_rd, w_rd, a_rd;
	logic signed [15:0] xb_prod, xw_prod;
	logic signed [ACC_W-1:0] xb_q, base_q;
	logic signed [PW-1:0] pert_prod, pert_q;
	logic signed [SW-1:0] pert_ext, pert_sgn, sum_q, tot, clamped;
	logic signed [7:0]  result_value_q;
	logic [7:0]         result_row_q;

	// Decode the request
	assign row16   = {8'b0, row};
	assign col16   = {8'b0, col};
	assign row_ok  = row16 < 16'(ROWS);
	assign col_ok  = col16 < 16'(COLS);
	assign row_ix  = row16[RIW-1:0];
	assign col_ix  = col16[CIW-1:0];
	assign is_comp = (cmd == CMD_COMPUTE);

	assign row_base = WAW'(32'(row) * 32'(COLS));
	assign w_waddr  = WAW'(32'(row) * 32'(COLS) + 32'(col));
	assign w_raddr  = base_addr_q + WAW'(j_q);

	// Saturate the column count to the store width
	assign cols_eff = ({2'b0, cols_in_use} > 11'(COLS)) ? CW'(COLS) : CW'(cols_in_use);

	assign dp_stat.comp_ok  = is_comp && row_ok;
	assign dp_stat.n_zero   = (cols_eff == '0);
	assign dp_stat.last_col = (j_q == n_q - CW'(1));

	pimv_ram #(.WIDTH(8), .DEPTH(ROWS * COLS), .AW(WAW)) u_w_ram (
		.clk   (clk),
		.we    (dp_cmd.accept && cmd == CMD_WR_W && row_ok && col_ok),
		.waddr (w_waddr),
		.wdata (value),
		.re    (dp_cmd.rd_en),
		.raddr (w_raddr),
		.rdata (w_rd)
	);

	pimv_ram #(.WIDTH(8), .DEPTH(ROWS), .AW(RIW)) u_a_ram (
		.clk   (clk),
		.we    (dp_cmd.accept && cmd == CMD_WR_A && row_ok),
		.waddr (row_ix),
		.wdata (value),
		.re    (dp_cmd.accept && is_comp),
		.raddr (row_ix),
		.rdata (a_rd)
	);

	pimv_ram #(.WIDTH(8), .DEPTH(COLS), .AW(CIW)) u_b_ram (
		.clk   (clk),
		.we    (dp_cmd.accept && cmd == CMD_WR_B && col_ok),
		.waddr (col_ix),
		.wdata (value),
		.re    (dp_cmd.rd_en),
		.raddr (j_q[CIW-1:0]),
		.rdata (b_rd)
	);

	pimv_ram #(.WIDTH(8), .DEPTH(COLS), .AW(CIW)) u_x_ram (
		.clk   (clk),
		.we    (dp_cmd.accept && cmd == CMD_WR_X && col_ok),
		.waddr (col_ix),
		.wdata (value),
		.re    (dp_cmd.rd_en),
		.raddr (j_q[CIW-1:0]),
		.rdata (x_rd)
	);

	// Column counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			j_q <= '0;
			n_q <= '0;
		end else if (dp_cmd.accept) begin
			j_q <= '0;
			n_q <= cols_eff;
		end else if (dp_cmd.rd_en) begin
			j_q <= j_q + CW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (dp_cmd.accept) begin
			base_addr_q <= row_base;
			neg_q       <= negate;
			row_q       <= row;
		end
	end

	assign xb_prod   = x_rd * b_rd;
	assign xw_prod   = x_rd * w_rd;
	assign pert_prod = xb_q * a_rd;
	assign pert_ext  = SW'(pert_q);
	assign pert_sgn  = neg_q ? -pert_ext : pert_ext;

	always_ff @(posedge clk) begin
		if (dp_cmd.accept) begin
			xb_q   <= '0;
			base_q <= '0;
		end else if (dp_cmd.mac_en) begin
			xb_q   <= xb_q + ACC_W'(xb_prod);
			base_q <= base_q + ACC_W'(xw_prod);
		end
		if (dp_cmd.pert_en) begin
			pert_q <= pert_prod;
		end
		if (dp_cmd.sum_en) begin
			// Negate first, then floor-shift the perturbation
			sum_q <= SW'(base_q) + (pert_sgn >>> PERT_SHIFT);
		end
	end

	assign tot = sum_q >>> TOT_SHIFT;

	always_comb begin
		if (tot > SW'(CLAMP_HI)) begin
			clamped = SW'(CLAMP_HI);
		end else if (tot < SW'(CLAMP_LO)) begin
			clamped = SW'(CLAMP_LO);
		end else begin
			clamped = tot;
		end
	end

	always_ff @(posedge clk) begin
		if (dp_cmd.out_load) begin
			result_value_q <= clamped[7:0];
			result_row_q   <= row_q;
		end
	end

	assign result_value = result_value_q;
	assign result_row   = result_row_q;

endmodule

@@ src/pimv_ctrl.sv @@
// Controller: sequences request intake, column sweep, perturbation, sum and result handoff.
`timescale 1ns / 1ps
module pimv_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	output logic               out_valid,
	input  logic               out_ready,
	input  pimv_pkg::dp_stat_t dp_stat,
	output pimv_pkg::dp_cmd_t  dp_cmd
);
	import pimv_pkg::*;

	typedef enum logic [5:0] {
		S_IDLE  = 6'b000001,
		S_RUN   = 6'b000010,
		S_DRAIN = 6'b000100,
		S_PERT  = 6'b001000,
		S_SUM   = 6'b010000,
		S_OUT   = 6'b100000
	} state_t;

	state_t state_q, state_d;
	logic   rd_d_q;
	logic   out_valid_q;
	logic   accept;
	logic   out_free;

	assign in_ready = (state_q == S_IDLE);
	assign accept   = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;

	always_comb begin
		state_d = state_q;
		dp_cmd  = '0;
		dp_cmd.accept = accept;
		dp_cmd.mac_en = rd_d_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept && dp_stat.comp_ok) begin
					state_d = dp_stat.n_zero ? S_PERT : S_RUN;
				end
			end
			S_RUN: begin
				dp_cmd.rd_en = 1'b1;
				if (dp_stat.last_col) begin
					state_d = S_DRAIN;
				end
			end
			S_DRAIN: begin
				state_d = S_PERT;
			end
			S_PERT: begin
				dp_cmd.pert_en = 1'b1;
				state_d = S_SUM;
			end
			S_SUM: begin
				dp_cmd.sum_en = 1'b1;
				state_d = S_OUT;
			end
			S_OUT: begin
				// Hold until the output register is free
				if (out_free) begin
					dp_cmd.out_load = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rd_d_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			rd_d_q  <= dp_cmd.rd_en;
			if (dp_cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule

@@ test/perturbed_int8_matvec_row_core_tb.sv @@
// Self-checking testbench for the perturbed int8 matvec row core.
`timescale 1ns / 1ps
module perturbed_int8_matvec_row_core_tb;
	import pimv_pkg::*;

	localparam int COLS_N = 256;
	localparam int PERT_SHR = 4;
	localparam int TOT_SHR = 8;
	localparam longint CLAMP_MAX = 127;
	localparam longint CLAMP_MIN = -127;
	localparam int IDLE_PCT = 19;
	localparam int HOLD_CYCLES = 400;
	localparam int SETTLE_CYCLES = 4;
	localparam int DRAIN_CYCLES = 270;
	localparam int CYCLE_LIMIT = 1000000;
	localparam logic [2:0] CMD_UNUSED_FIRST = 3'd5;
	localparam logic [2:0] CMD_UNUSED_LAST = 3'd7;
	localparam logic [2:0] REG_COLS_ADDR = 3'd0;

	typedef struct packed {
		logic [2:0] cmd;
		logic [7:0] row;
		logic [7:0] col;
		logic signed [7:0] value;
		logic negate;
	} request_t;

	typedef struct packed {
		logic signed [7:0] value;
		logic [7:0] row;
	} row_result_t;

	// Mirror of the stores plus the queue of row results still owed by the block.
	class row_scoreboard;
		logic signed [7:0] w_mem [0:65535];
		logic signed [7:0] a_mem [0:255];
		logic signed [7:0] b_mem [0:255];
		logic signed [7:0] x_mem [0:255];
		logic [8:0] cols;
		row_result_t owed_q[$];
		int errors;

		function new();
			cols = COLS_RESET;
			errors = 0;
		endfunction

		function int pending();
			return owed_q.size();
		endfunction

		function row_result_t predict_row(logic [7:0] r, logic neg);
			longint xb, acc, pert, tot;
			int lim, j;
			xb = 0;
			acc = 0;
			lim = (cols > 9'(COLS_N)) ? COLS_N : int'(cols);
			for (j = 0; j < lim; j++) begin
				xb += longint'(x_mem[j]) * longint'(b_mem[j]);
				acc += longint'(x_mem[j]) * longint'(w_mem[{r, 8'(j)}]);
			end
			pert = xb * longint'(a_mem[r]);
			if (neg)
				pert = -pert;
			pert = pert >>> PERT_SHR;
			tot = (acc + pert) >>> TOT_SHR;
			if (tot > CLAMP_MAX)
				tot = CLAMP_MAX;
			if (tot < CLAMP_MIN)
				tot = CLAMP_MIN;
			return '{value: 8'(tot), row: r};
		endfunction

		function void note_request(request_t req);
			case (req.cmd)
				CMD_WR_W: w_mem[{req.row, req.col}] = req.value;
				CMD_WR_A: a_mem[req.row] = req.value;
				CMD_WR_B: b_mem[req.col] = req.value;
				CMD_WR_X: x_mem[req.col] = req.value;
				CMD_COMPUTE: owed_q.push_back(predict_row(req.row, req.negate));
				default: ;
			endcase
		endfunction

		function void check_result(logic signed [7:0] v, logic [7:0] r);
			row_result_t exp_res;
			if (owed_q.size() == 0) begin
				$error("result_row %0d result_value %0d arrived with no compute outstanding", r, v);
				errors++;
				return;
			end
			exp_res = owed_q.pop_front();
			if (v !== exp_res.value) begin
				$error("result_value: expected %0d, got %0d", exp_res.value, v);
				errors++;
			end
			if (r !== exp_res.row) begin
				$error("result_row: expected %0d, got %0d", exp_res.row, r);
				errors++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [2:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [2:0] cmd = '0;
	logic [7:0] row = '0;
	logic [7:0] col = '0;
	logic signed [7:0] value = '0;
	logic negate = 1'b0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [7:0] result_value;
	logic [7:0] result_row;

	perturbed_int8_matvec_row_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.cmd(cmd),
		.row(row),
		.col(col),
		.value(value),
		.negate(negate),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.result_value(result_value),
		.result_row(result_row)
	);

	row_scoreboard sb;
	bit idle_on = 1'b1;
	bit hold_request = 1'b0;
	int hold_left = 0;
	int cycles = 0;
	int requests_sent = 0;

	// Which store entries the stimulus has written so far.
	bit w_wr [0:65535];
	bit a_wr [0:255];
	bit b_wr [0:255];
	bit x_wr [0:255];
	bit touched [0:255];
	int touched_q[$];
	request_t plan_q[$];

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles == CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready)
				sb.check_result(result_value, result_row);
			if (in_valid && in_ready)
				sb.note_request('{cmd, row, col, value, negate});
		end
	end

	// Receiver: random stalls, plus one long hold-off counted here.
	always @(negedge clk) begin
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else if (hold_request) begin
			hold_request = 1'b0;
			hold_left = HOLD_CYCLES;
			out_ready <= 1'b0;
		end else begin
			out_ready <= !(idle_on && $urandom_range(0, 99) < IDLE_PCT);
		end
	end

	task automatic send_request(request_t req);
		@(negedge clk);
		while (idle_on && $urandom_range(0, 99) < IDLE_PCT) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		cmd <= req.cmd;
		row <= req.row;
		col <= req.col;
		value <= req.value;
		negate <= req.negate;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		if (req.cmd <= CMD_COMPUTE)
			requests_sent++;
	endtask

	task automatic drain_plan();
		while (plan_q.size() != 0)
			send_request(plan_q.pop_front());
	endtask

	task automatic apb_access(input bit wr, input logic [2:0] addr, input logic [31:0] data,
			output logic [31:0] rd);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= addr;
		pwdata <= data;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		rd = prdata;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic check_cols(int expected);
		logic [31:0] rd;
		apb_access(1'b0, REG_COLS_ADDR, '0, rd);
		if (rd[8:0] !== 9'(expected)) begin
			$error("cols_in_use: expected %0d, got %0d", expected, rd[8:0]);
			sb.errors++;
		end
	endtask

	// Drop valid and let every owed result come back before touching registers.
	task automatic wait_idle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_cols(int v);
		logic [31:0] rd;
		wait_idle();
		apb_access(1'b1, REG_COLS_ADDR, 32'(v), rd);
		check_cols(v);
		sb.cols = 9'(v);
	endtask

	function automatic request_t make_write(logic [2:0] c, int r, int k, logic signed [7:0] v);
		request_t req;
		req = '{cmd: c, row: 8'(r), col: 8'(k), value: v, negate: 1'($urandom)};
		case (c)
			CMD_WR_W: w_wr[r * COLS_N + k] = 1'b1;
			CMD_WR_A: a_wr[r] = 1'b1;
			CMD_WR_B: b_wr[k] = 1'b1;
			CMD_WR_X: x_wr[k] = 1'b1;
			default: ;
		endcase
		return req;
	endfunction

	function automatic request_t rand_write();
		return make_write(3'($urandom_range(CMD_WR_W, CMD_WR_X)), $urandom_range(0, 255),
			$urandom_range(0, 255), 8'($urandom));
	endfunction

	function automatic request_t make_compute(int r, logic neg);
		return '{cmd: CMD_COMPUTE, row: 8'(r), col: 8'($urandom), value: 8'($urandom), negate: neg};
	endfunction

	function automatic int eff_cols(int n);
		return (n > COLS_N) ? COLS_N : n;
	endfunction

	function automatic bit row_ready(int r, int n);
		int j;
		if (!a_wr[r])
			return 1'b0;
		for (j = 0; j < eff_cols(n); j++)
			if (!(x_wr[j] && b_wr[j] && w_wr[r * COLS_N + j]))
				return 1'b0;
		return 1'b1;
	endfunction

	// Fill whatever the row still lacks, tweak a few entries, then compute it.
	function automatic void plan_row(int r, int n);
		int lim, j, extra;
		lim = eff_cols(n);
		for (j = 0; j < lim; j++) begin
			if (!x_wr[j])
				plan_q.push_back(make_write(CMD_WR_X, $urandom_range(0, 255), j, 8'($urandom)));
			if (!b_wr[j])
				plan_q.push_back(make_write(CMD_WR_B, $urandom_range(0, 255), j, 8'($urandom)));
			if (!w_wr[r * COLS_N + j])
				plan_q.push_back(make_write(CMD_WR_W, r, j, 8'($urandom)));
		end
		if (!a_wr[r])
			plan_q.push_back(make_write(CMD_WR_A, r, $urandom_range(0, 255), 8'($urandom)));
		extra = $urandom_range(0, 2);
		if (lim > 0)
			repeat (extra)
				plan_q.push_back(make_write(3'($urandom_range(CMD_WR_W, CMD_WR_X)), r,
					$urandom_range(0, lim - 1), 8'($urandom)));
		plan_q.push_back(make_compute(r, 1'($urandom)));
		if (!touched[r]) begin
			touched[r] = 1'b1;
			touched_q.push_back(r);
		end
	endfunction

	function automatic void plan_action(int n);
		int pick, r;
		pick = $urandom_range(0, 99);
		if (pick < 50) begin
			if (touched_q.size() != 0 && $urandom_range(0, 1) == 1)
				r = touched_q[$urandom_range(0, touched_q.size() - 1)];
			else
				r = $urandom_range(0, 255);
			plan_row(r, n);
		end else if (pick < 75) begin
			plan_q.push_back(rand_write());
		end else if (pick < 85) begin
			plan_q.push_back('{cmd: 3'($urandom_range(CMD_UNUSED_FIRST, CMD_UNUSED_LAST)),
				row: 8'($urandom), col: 8'($urandom), value: 8'($urandom),
				negate: 1'($urandom)});
		end else begin
			r = (touched_q.size() != 0) ? touched_q[$urandom_range(0, touched_q.size() - 1)] : 0;
			if (touched_q.size() != 0 && row_ready(r, n))
				plan_q.push_back(make_compute(r, 1'($urandom)));
			else
				plan_q.push_back(rand_write());
		end
	endfunction

	task automatic run_phase(int n, int count, bit hold, bit quiet);
		int start;
		set_cols(n);
		idle_on = !quiet;
		if (hold)
			hold_request = 1'b1;
		start = requests_sent;
		while (requests_sent - start < count) begin
			plan_action(n);
			drain_plan();
		end
		if (hold) begin
			// Keep offering computes while the receiver holds off.
			plan_row(touched_q[0], n);
			repeat (3)
				plan_q.push_back(make_compute(touched_q[0], 1'($urandom)));
			drain_plan();
		end
		idle_on = 1'b1;
	endtask

	initial begin
		int j;
		sb = new();
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		check_cols(COLS_RESET);

		// Directed: extreme values, both clamp rails, both signs, unused commands.
		set_cols(4);
		for (j = 0; j < 4; j++) begin
			plan_q.push_back(make_write(CMD_WR_X, 0, j, -8'sd128));
			plan_q.push_back(make_write(CMD_WR_B, 255, j, 8'sd127));
			plan_q.push_back(make_write(CMD_WR_W, 255, j, -8'sd128));
			plan_q.push_back(make_write(CMD_WR_W, 0, j, 8'sd127));
		end
		plan_q.push_back(make_write(CMD_WR_A, 255, 0, 8'sd0));
		plan_q.push_back(make_write(CMD_WR_A, 0, 255, 8'sd0));
		plan_q.push_back(make_compute(255, 1'b0));
		plan_q.push_back(make_compute(0, 1'b1));
		plan_q.push_back(make_write(CMD_WR_A, 255, 0, -8'sd128));
		plan_q.push_back(make_write(CMD_WR_A, 0, 0, 8'sd127));
		plan_q.push_back(make_compute(255, 1'b1));
		plan_q.push_back(make_compute(0, 1'b0));
		for (j = CMD_UNUSED_FIRST; j <= CMD_UNUSED_LAST; j++)
			plan_q.push_back('{cmd: 3'(j), row: 8'hFF, col: 8'hFF, value: -8'sd1, negate: 1'b1});
		drain_plan();
		touched[0] = 1'b1;
		touched[255] = 1'b1;
		touched_q.push_back(0);
		touched_q.push_back(255);

		run_phase(0, 5, 1'b0, 1'b0);
		run_phase(3, 10, 1'b0, 1'b0);
		run_phase(1, 30, 1'b0, 1'b1);
		run_phase(12, 12, 1'b0, 1'b0);
		run_phase(5, 14, 1'b1, 1'b0);
		run_phase(16, 14, 1'b0, 1'b0);
		run_phase(2, 8, 1'b0, 1'b0);

		// Full width on one row, then a column count above the store width.
		set_cols(256);
		plan_row(0, 256);
		plan_q.push_back(make_compute(0, 1'b0));
		plan_q.push_back(make_compute(0, 1'b1));
		drain_plan();
		set_cols(511);
		plan_q.push_back(make_compute(0, 1'b1));
		plan_q.push_back(make_compute(0, 1'b0));
		plan_q.push_back(make_write(CMD_WR_A, 0, 0, 8'($urandom)));
		plan_q.push_back(make_compute(0, 1'b1));
		drain_plan();

		wait_idle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
